[rtl/dpf_pkg.sv]
package dpf_pkg;

    localparam int CHUNK_BYTES = 16;
    localparam int BYTE_W      = 8;
    localparam int CHUNK_W     = CHUNK_BYTES * BYTE_W;
    localparam int HALF_W      = CHUNK_W / 2;
    localparam int IDX_W       = 10;
    localparam int INTERVAL_W  = 16;
    localparam int TIME_W      = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;
    localparam logic [7:0]            PAGE_CMD_BASE  = 8'hB0;

    typedef logic [1:0] op_t;

    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_FLUSH = 2'd1;
    localparam op_t OP_TICK  = 2'd2;
    localparam op_t OP_INVAL = 2'd3;

    typedef struct packed {
        logic flush_req;
        logic tick;
    } pace_cmd_t;

    typedef struct packed {
        logic go;
        logic snap_valid;
    } flush_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } flush_sts_t;

    typedef struct packed {
        logic [2:0]        page_number;
        logic [2:0]        chunk_number;
        logic [7:0]        page_command;
        logic [HALF_W-1:0] chunk_low;
        logic [HALF_W-1:0] chunk_high;
        logic              last_chunk;
    } result_t;

endpackage

[rtl/dpf_ram.sv]
module dpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/dpf_pace.sv]
module dpf_pace (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [dpf_pkg::INTERVAL_W-1:0] cfg_data,
    input  dpf_pkg::pace_cmd_t         cmd,
    output logic                       launch
);

    import dpf_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [TIME_W-1:0]     elapsed_reg;
    logic [TIME_W-1:0]     elapsed_next;
    logic [TIME_W-1:0]     elapsed_inc;
    logic [TIME_W-1:0]     interval_ext;
    logic                  pending_reg;
    logic                  pending_next;

    assign interval_ext = TIME_W'(interval_reg);
    assign elapsed_inc  = elapsed_reg + TIME_W'(1);

    // elapsed_reg is tick count minus the tick of the last flush, modulo 2^32
    always_comb
    begin
        launch       = 1'b0;
        elapsed_next = elapsed_reg;
        pending_next = pending_reg;
        if (cmd.flush_req)
        begin
            if (elapsed_reg < interval_ext)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                launch       = 1'b1;
                pending_next = 1'b0;
                elapsed_next = '0;
            end
        end
        else if (cmd.tick)
        begin
            elapsed_next = elapsed_inc;
            if (pending_reg && !(elapsed_inc < interval_ext))
            begin
                launch       = 1'b1;
                pending_next = 1'b0;
                elapsed_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            elapsed_reg  <= '0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                interval_reg <= cfg_data;
            end
            elapsed_reg <= elapsed_next;
            pending_reg <= pending_next;
        end
    end

endmodule

[rtl/dpf_flush.sv]
module dpf_flush #(
    parameter int PAGE_COUNT = 8,
    parameter int PAGE_BYTES = 128,
    localparam int AW = $clog2(PAGE_COUNT * PAGE_BYTES)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dpf_pkg::flush_ctl_t        ctl,
    output dpf_pkg::flush_sts_t        sts,
    output logic [AW-1:0]              frame_raddr,
    input  logic [dpf_pkg::BYTE_W-1:0] frame_rdata,
    output logic                       strobe,
    output dpf_pkg::result_t           result
);

    import dpf_pkg::*;

    localparam int STORE  = PAGE_COUNT * PAGE_BYTES;
    localparam int CHUNKS = (PAGE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int SPAN   = CHUNKS * CHUNK_BYTES;
    localparam int COL_W  = $clog2(SPAN);
    localparam int SUB_W  = $clog2(CHUNK_BYTES);
    localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMP   = 3'd1;
    localparam logic [2:0] ST_FIND  = 3'd2;
    localparam logic [2:0] ST_SEND  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [PG_W-1:0]       page_reg, page_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [PAGE_COUNT-1:0] send_reg, send_next;

    logic                  d_valid_reg;
    logic                  d_send_reg;
    logic                  d_inrange_reg;
    logic [PG_W-1:0]       d_page_reg;
    logic [COL_W-1:0]      d_col_reg;
    logic [AW-1:0]         d_addr_reg;

    logic [CHUNK_W-1:0]    shift_reg, shift_next;
    logic                  strobe_reg, strobe_next;
    result_t               result_reg, result_next;

    logic                  issue;
    logic                  page_last;
    logic                  col_inrange;
    logic [AW-1:0]         cur_addr;
    logic [BYTE_W-1:0]     snap_rdata;
    logic [BYTE_W-1:0]     fill_byte;
    logic [COL_W-1:0]      chunk_idx;
    logic [PG_W-1:0]       last_pg;
    logic [2:0]            page3;
    logic                  snap_we;

    assign page_last   = (page_reg == PG_W'(PAGE_COUNT - 1));
    assign col_inrange = (32'(col_reg) < PAGE_BYTES);
    assign cur_addr    = base_reg + AW'(col_reg);
    assign frame_raddr = cur_addr;

    // highest page marked for sending carries the final chunk
    always_comb
    begin
        last_pg = '0;
        for (int i = 0; i < PAGE_COUNT; i++)
        begin
            if (send_reg[i])
            begin
                last_pg = PG_W'(i);
            end
        end
    end

    // sequencer: with a valid snapshot walk both stores page by page, then send marked pages
    always_comb
    begin
        state_next = state_reg;
        page_next  = page_reg;
        base_next  = base_reg;
        col_next   = col_reg;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.go)
                begin
                    page_next  = '0;
                    base_next  = '0;
                    col_next   = '0;
                    state_next = ctl.snap_valid ? ST_CMP : ST_SEND;
                end
            end
            ST_CMP:
            begin
                issue = 1'b1;
                if (col_reg == COL_W'(PAGE_BYTES - 1))
                begin
                    col_next = '0;
                    if (page_last)
                    begin
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        page_next = page_reg + PG_W'(1);
                        base_next = base_reg + AW'(PAGE_BYTES);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            ST_FIND:
            begin
                page_next  = '0;
                base_next  = '0;
                col_next   = '0;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (send_reg[page_reg] && (col_reg != COL_W'(SPAN - 1)))
                begin
                    issue    = 1'b1;
                    col_next = col_reg + COL_W'(1);
                end
                else
                begin
                    issue    = send_reg[page_reg];
                    col_next = '0;
                    if (page_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        page_next = page_reg + PG_W'(1);
                        base_next = base_reg + AW'(PAGE_BYTES);
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // data stage: one byte per cycle through the compare and chunk unit
    always_comb
    begin
        send_next   = send_reg;
        shift_next  = shift_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        fill_byte   = d_inrange_reg ? frame_rdata : '0;
        chunk_idx   = d_col_reg >> SUB_W;
        page3       = 3'(d_page_reg);
        snap_we     = d_valid_reg && d_send_reg && d_inrange_reg;

        if (d_valid_reg && !d_send_reg && (frame_rdata != snap_rdata))
        begin
            send_next[d_page_reg] = 1'b1;
        end
        if (d_valid_reg && d_send_reg)
        begin
            shift_next = {fill_byte, shift_reg[CHUNK_W-1:BYTE_W]};
            if (d_col_reg[SUB_W-1:0] == SUB_W'(CHUNK_BYTES - 1))
            begin
                strobe_next              = 1'b1;
                result_next.page_number  = page3;
                result_next.chunk_number = 3'(chunk_idx);
                result_next.page_command = PAGE_CMD_BASE | {5'b0, page3};
                result_next.chunk_low    = shift_next[HALF_W-1:0];
                result_next.chunk_high   = shift_next[CHUNK_W-1:HALF_W];
                result_next.last_chunk   = (d_page_reg == last_pg)
                                           && (chunk_idx == COL_W'(CHUNKS - 1));
            end
        end
        if (state_reg == ST_IDLE && ctl.go)
        begin
            send_next = ctl.snap_valid ? '0 : '1;
        end
    end

    dpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE)
    ) u_snap (
        .clk   (clk),
        .we    (snap_we),
        .waddr (d_addr_reg),
        .wdata (frame_rdata),
        .raddr (cur_addr),
        .rdata (snap_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            d_valid_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            d_valid_reg <= issue;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        base_reg      <= base_next;
        col_reg       <= col_next;
        send_reg      <= send_next;
        d_send_reg    <= (state_reg == ST_SEND);
        d_inrange_reg <= col_inrange;
        d_page_reg    <= page_reg;
        d_col_reg     <= col_reg;
        d_addr_reg    <= cur_addr;
        shift_reg     <= shift_next;
        result_reg    <= result_next;
    end

    assign sts.busy = (state_reg != ST_IDLE);
    assign sts.done = (state_reg == ST_DRAIN);
    assign strobe   = strobe_reg;
    assign result   = result_reg;

endmodule

[rtl/dirty_page_display_flush_top.sv]
// Dirty-page display flush engine.
// Input channel: drive operation, byte_index and byte_value with start; the
// item is taken at a rising edge where start is high and busy is low.
// Operations: write one frame byte, request a flush, advance one tick, or
// invalidate the snapshot of what was last sent.
// Config channel: cfg_valid/cfg_ready/cfg_data writes min_flush_interval;
// cfg_ready is always high, so every cfg_valid cycle is a write.
// Result channel: each 16-byte chunk shows for one cycle with strobe high.
// The receiver cannot stall; results have no back-pressure.
// Flow: write, tick, invalidate and a held-off flush leave busy low, so they
// go back to back, but a tick that releases a held flush starts one. A flush
// walks the stores one byte per cycle through a single byte compare and chunk
// unit with busy high: with a valid snapshot, a compare sweep over every page
// and a find step; then each page in order, skipped if unchanged or read out
// in zero-padded 16-byte chunks if sent; then a drain step. Without a valid
// snapshot every page is sent. Chunks leave in page order, chunk by chunk;
// the final strobe may show after busy has dropped.
// Reset: a clearing pass zeroes every byte of the frame store with busy high;
// config writes still land.
module dirty_page_display_flush_top #(
    parameter int PAGE_COUNT = 8,
    parameter int PAGE_BYTES = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [dpf_pkg::IDX_W-1:0]      byte_index,
    input  logic [dpf_pkg::BYTE_W-1:0]     byte_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpf_pkg::INTERVAL_W-1:0] cfg_data,
    output logic                           strobe,
    output logic [2:0]                     page_number,
    output logic [2:0]                     chunk_number,
    output logic [7:0]                     page_command,
    output logic [dpf_pkg::HALF_W-1:0]     chunk_low,
    output logic [dpf_pkg::HALF_W-1:0]     chunk_high,
    output logic                           last_chunk
);

    import dpf_pkg::*;

    localparam int STORE = PAGE_COUNT * PAGE_BYTES;
    localparam int AW    = $clog2(STORE);

    logic              clearing_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              snap_valid_reg, snap_valid_next;
    logic              accept;
    logic              wr_item;
    logic              inval_item;
    logic              in_range;
    pace_cmd_t         pace_cmd;
    logic              launch;
    flush_ctl_t        fctl;
    flush_sts_t        fsts;
    logic              frame_we;
    logic [AW-1:0]     frame_waddr;
    logic [BYTE_W-1:0] frame_wdata;
    logic [AW-1:0]     frame_raddr;
    logic [BYTE_W-1:0] frame_rdata;
    result_t           result;

    // hold input off during the clearing pass and while a flush runs
    assign busy      = clearing_reg | fsts.busy;
    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;
    assign in_range  = (32'(byte_index) < STORE);

    always_comb
    begin
        wr_item            = 1'b0;
        inval_item         = 1'b0;
        pace_cmd.flush_req = 1'b0;
        pace_cmd.tick      = 1'b0;
        unique case (operation)
            OP_WRITE: wr_item            = accept;
            OP_FLUSH: pace_cmd.flush_req = accept;
            OP_TICK:  pace_cmd.tick      = accept;
            OP_INVAL: inval_item         = accept;
            default:  wr_item            = 1'b0;
        endcase
    end

    // drop writes beyond the store; the clearing pass owns the write port
    assign frame_we    = clearing_reg | (wr_item & in_range);
    assign frame_waddr = clearing_reg ? clr_addr_reg : AW'(byte_index);
    assign frame_wdata = clearing_reg ? '0 : byte_value;

    dpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE)
    ) u_frame (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    dpf_pace u_pace (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (pace_cmd),
        .launch    (launch)
    );

    assign fctl.go         = launch;
    assign fctl.snap_valid = snap_valid_reg;

    dpf_flush #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_flush (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (fctl),
        .sts         (fsts),
        .frame_raddr (frame_raddr),
        .frame_rdata (frame_rdata),
        .strobe      (strobe),
        .result      (result)
    );

    // snapshot turns valid once a flush has copied every sent page
    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (inval_item)
        begin
            snap_valid_next = 1'b0;
        end
        else if (fsts.done)
        begin
            snap_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    assign page_number  = result.page_number;
    assign chunk_number = result.chunk_number;
    assign page_command = result.page_command;
    assign chunk_low    = result.chunk_low;
    assign chunk_high   = result.chunk_high;
    assign last_chunk   = result.last_chunk;

endmodule

[rtl/dpf_checker.sv]
module dpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       strobe,
    input logic [2:0] page_number,
    input logic [7:0] page_command,
    input logic       last_chunk
);

    import dpf_pkg::*;

    // chunks are assembled one byte a cycle, so strobes never touch
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("strobe high on two cycles in a row");

    // only the final chunk may leave after the engine goes idle
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_chunk |-> busy)
        else $error("non-final chunk while not busy");

    a_page_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (page_command[7:3] == PAGE_CMD_BASE[7:3])
                   && (page_command[2:0] == page_number))
        else $error("page command does not match page number");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_WRITE) |=> !busy)
        else $error("frame byte write made the block busy");

endmodule

bind dirty_page_display_flush_top dpf_checker u_dpf_checker (.*);

[sim/dirty_page_display_flush_top_tb.sv]
// Scoreboard: tracks the frame, the last-sent snapshot and the flush pacing,
// and queues the chunks each accepted item must produce.
class chunk_scoreboard #(int PAGES = 8, int PAGE_LEN = 128);

    dpf_pkg::result_t want_chunks[$];
    logic [7:0]       frame_img [PAGES*PAGE_LEN];
    logic [7:0]       sent_img  [PAGES*PAGE_LEN];
    bit               sent_ok;
    bit               hold_flush;
    logic [31:0]      now_ticks;
    logic [31:0]      last_ticks;
    logic [15:0]      interval;
    int               mismatches;

    function new();
        foreach (frame_img[i])
        begin
            frame_img[i] = 8'h00;
            sent_img[i]  = 8'h00;
        end
        sent_ok    = 0;
        hold_flush = 0;
        now_ticks  = 32'd0;
        last_ticks = 32'd0;
        interval   = dpf_pkg::INTERVAL_RESET;
        mismatches = 0;
    endfunction

    function void set_interval(logic [15:0] value);
        interval = value;
    endfunction

    // Elapsed ticks wrap modulo 2^32.
    function bit interval_met();
        logic [31:0] elapsed;
        elapsed = now_ticks - last_ticks;
        return elapsed >= {16'd0, interval};
    endfunction

    function void flush_frame();
        bit               send_page [PAGES];
        int               last_page;
        int               per_page;
        int               pos;
        dpf_pkg::result_t chunk;
        per_page  = (PAGE_LEN + dpf_pkg::CHUNK_BYTES - 1) / dpf_pkg::CHUNK_BYTES;
        last_page = -1;
        for (int p = 0; p < PAGES; p++)
        begin
            send_page[p] = !sent_ok;
            for (int b = 0; b < PAGE_LEN; b++)
                if (frame_img[p*PAGE_LEN+b] != sent_img[p*PAGE_LEN+b])
                    send_page[p] = 1;
            if (send_page[p])
                last_page = p;
        end
        for (int p = 0; p < PAGES; p++)
        begin
            if (!send_page[p])
                continue;
            for (int c = 0; c < per_page; c++)
            begin
                chunk.page_number  = 3'(p);
                chunk.chunk_number = 3'(c);
                chunk.page_command = dpf_pkg::PAGE_CMD_BASE | 8'(p & 7);
                chunk.chunk_low    = '0;
                chunk.chunk_high   = '0;
                for (int i = 0; i < 8; i++)
                begin
                    pos = c * dpf_pkg::CHUNK_BYTES + i;
                    if (pos < PAGE_LEN)
                        chunk.chunk_low[8*i +: 8] = frame_img[p*PAGE_LEN+pos];
                    if (pos + 8 < PAGE_LEN)
                        chunk.chunk_high[8*i +: 8] = frame_img[p*PAGE_LEN+pos+8];
                end
                chunk.last_chunk = (p == last_page) && (c == per_page - 1);
                want_chunks.push_back(chunk);
            end
            for (int b = 0; b < PAGE_LEN; b++)
                sent_img[p*PAGE_LEN+b] = frame_img[p*PAGE_LEN+b];
        end
        sent_ok = 1;
    endfunction

    function void note_item(dpf_pkg::op_t op, logic [dpf_pkg::IDX_W-1:0] idx,
                            logic [7:0] value);
        case (op)
            dpf_pkg::OP_WRITE:
            begin
                if (int'(idx) < PAGES*PAGE_LEN)
                    frame_img[idx] = value;
            end
            dpf_pkg::OP_FLUSH:
            begin
                if (!interval_met())
                    hold_flush = 1;
                else
                begin
                    last_ticks = now_ticks;
                    hold_flush = 0;
                    flush_frame();
                end
            end
            dpf_pkg::OP_TICK:
            begin
                now_ticks = now_ticks + 32'd1;
                if (hold_flush && interval_met())
                begin
                    last_ticks = now_ticks;
                    hold_flush = 0;
                    flush_frame();
                end
            end
            default:
                sent_ok = 0;
        endcase
    endfunction

    task flag_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task check_chunk(dpf_pkg::result_t got);
        dpf_pkg::result_t want;
        if (want_chunks.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected chunk page %0d chunk %0d",
                                    got.page_number, got.chunk_number));
            return;
        end
        want = want_chunks.pop_front();
        if (got.page_number !== want.page_number)
            flag_mismatch($sformatf("page_number got %0d want %0d",
                                    got.page_number, want.page_number));
        if (got.chunk_number !== want.chunk_number)
            flag_mismatch($sformatf("chunk_number got %0d want %0d",
                                    got.chunk_number, want.chunk_number));
        if (got.page_command !== want.page_command)
            flag_mismatch($sformatf("page_command got %h want %h",
                                    got.page_command, want.page_command));
        if (got.chunk_low !== want.chunk_low)
            flag_mismatch($sformatf("chunk_low got %h want %h",
                                    got.chunk_low, want.chunk_low));
        if (got.chunk_high !== want.chunk_high)
            flag_mismatch($sformatf("chunk_high got %h want %h",
                                    got.chunk_high, want.chunk_high));
        if (got.last_chunk !== want.last_chunk)
            flag_mismatch($sformatf("last_chunk got %0d want %0d",
                                    got.last_chunk, want.last_chunk));
    endtask

endclass

module dirty_page_display_flush_top_tb;

    import dpf_pkg::*;

    localparam int PAGES    = 8;
    localparam int PAGE_LEN = 128;
    localparam int SWEEP    = PAGES * PAGE_LEN;
    // Worst flush: full compare sweep, every page sent, plus margin.
    localparam int FLUSH_CYCLES = 2 * SWEEP + 64;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            operation;
    logic [IDX_W-1:0]      byte_index;
    logic [BYTE_W-1:0]     byte_value;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INTERVAL_W-1:0] cfg_data;
    logic                  strobe;
    logic [2:0]            page_number;
    logic [2:0]            chunk_number;
    logic [7:0]            page_command;
    logic [HALF_W-1:0]     chunk_low;
    logic [HALF_W-1:0]     chunk_high;
    logic                  last_chunk;

    chunk_scoreboard #(PAGES, PAGE_LEN) sb;
    bit                                 idle_on;

    dirty_page_display_flush_top #(
        .PAGE_COUNT(PAGES),
        .PAGE_BYTES(PAGE_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .byte_index(byte_index),
        .byte_value(byte_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .page_number(page_number),
        .chunk_number(chunk_number),
        .page_command(page_command),
        .chunk_low(chunk_low),
        .chunk_high(chunk_high),
        .last_chunk(last_chunk)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block stalls or drops chunks.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Sample every strobed chunk at the rising edge that ends its cycle and
    // hand it to the scoreboard; the receiver never stalls.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && strobe)
        begin
            got.page_number  = page_number;
            got.chunk_number = chunk_number;
            got.page_command = page_command;
            got.chunk_low    = chunk_low;
            got.chunk_high   = chunk_high;
            got.last_chunk   = last_chunk;
            sb.check_chunk(got);
        end
    end

    // Offer one item from a falling edge and hold it until the block takes
    // it (start high, busy low at a rising edge). Insert random idle cycles
    // first when idling is on. Leave start high on return so that a
    // following item goes out back to back; callers that pause drop it.
    task send_item(op_t op, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
        while (idle_on && $urandom_range(99) < 25)
        begin
            start      = 1'b0;
            byte_value = BYTE_W'($urandom);
            @(negedge clk);
        end
        start      = 1'b1;
        operation  = op;
        byte_index = idx;
        byte_value = value;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(op, idx, value);
        @(negedge clk);
    endtask

    // Drop start and hold until every queued chunk has come out.
    task wait_results();
        start = 1'b0;
        while (sb.want_chunks.size() != 0)
            @(negedge clk);
    endtask

    // A flush that sends nothing leaves no trace in the queue, so wait out
    // the longest flush as well before touching the register.
    task wait_idle();
        wait_results();
        repeat (FLUSH_CYCLES) @(negedge clk);
    endtask

    task write_interval(logic [INTERVAL_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_interval(value);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = INTERVAL_W'($urandom);
    endtask

    // Random items with the given mix in percent; the remainder invalidates
    // the snapshot. Bias values toward all-zero and all-one bytes now and
    // then so that whole pages can revert and compare equal.
    task random_burst(int count, int pct_write, int pct_flush, int pct_tick);
        int               roll;
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       value;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < pct_write)
                op = OP_WRITE;
            else if (roll < pct_write + pct_flush)
                op = OP_FLUSH;
            else if (roll < pct_write + pct_flush + pct_tick)
                op = OP_TICK;
            else
                op = OP_INVAL;
            idx = IDX_W'($urandom_range(SWEEP - 1));
            case ($urandom_range(3))
                0:       value = 8'h00;
                1:       value = 8'hFF;
                default: value = 8'($urandom);
            endcase
            send_item(op, idx, value);
        end
    endtask

    initial
    begin
        start      = 1'b0;
        operation  = OP_WRITE;
        byte_index = '0;
        byte_value = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        idle_on    = 1;
        sb         = new();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Default interval: a request at tick zero is held off, and one tick
        // is not enough to release it.
        send_item(OP_WRITE, 10'd0, 8'hFF);
        send_item(OP_WRITE, 10'd1023, 8'h80);
        send_item(OP_WRITE, 10'd130, 8'h01);
        send_item(OP_FLUSH, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);

        // Shorten the interval; the next tick advances time first and then
        // releases the held request: the snapshot is invalid, so every page
        // goes out.
        wait_idle();
        write_interval(16'd2);
        send_item(OP_TICK, 10'd0, 8'h00);

        // Hold off a request right after a flush, release it two ticks later
        // with nothing changed: no chunks, but the hold clears.
        send_item(OP_FLUSH, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);

        // Dirty two pages; an immediate flush sends just those two.
        send_item(OP_WRITE, 10'd389, 8'h5A);
        send_item(OP_WRITE, 10'd767, 8'hA5);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_FLUSH, 10'd0, 8'h00);

        // Rewrite bytes with their current values: nothing to send.
        send_item(OP_WRITE, 10'd0, 8'hFF);
        send_item(OP_WRITE, 10'd640, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_FLUSH, 10'd0, 8'h00);

        // Invalidate: the next flush resends every page.
        send_item(OP_INVAL, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_TICK, 10'd0, 8'h00);
        send_item(OP_FLUSH, 10'd0, 8'h00);

        // Zero interval: every request flushes at once. Run the first
        // stretch with no idling at all.
        wait_idle();
        write_interval(16'd0);
        idle_on = 0;
        random_burst(40, 60, 15, 15);
        idle_on = 1;
        random_burst(20, 60, 15, 15);

        // Pause the sender until every queued chunk is out, then go on.
        wait_results();
        random_burst(20, 60, 15, 15);

        // Short random interval: requests are often held and released by
        // ticks.
        wait_idle();
        write_interval(INTERVAL_W'($urandom_range(1, 6)));
        random_burst(50, 45, 15, 35);

        // Longest interval: every request is held off.
        wait_idle();
        write_interval(16'hFFFF);
        random_burst(20, 40, 30, 20);

        // Drop back to a short interval; a held request goes out on the
        // first tick that meets it.
        wait_idle();
        write_interval(16'd5);
        random_burst(40, 45, 15, 35);

        // Drain and allow for a trailing empty flush before deciding.
        wait_idle();
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/dpf_pkg.sv
rtl/dpf_ram.sv
rtl/dpf_pace.sv
rtl/dpf_flush.sv
rtl/dirty_page_display_flush_top.sv
rtl/dpf_checker.sv
sim/dirty_page_display_flush_top_tb.sv
